>>> src/itp_pkg.sv
// Shared types and codes for the infix-to-postfix converter.
// No dependencies; itp_front, itp_back and the top level use this package.
`default_nettype none

package itp_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int VALUE_BITS_DEF  = 16;
	localparam int VAL_W           = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int ENT_W           = 3;

	// input token kinds
	localparam logic [1:0] TOK_OPERAND  = 2'd0;
	localparam logic [1:0] TOK_OPERATOR = 2'd1;
	localparam logic [1:0] TOK_LPAREN   = 2'd2;
	localparam logic [1:0] TOK_RPAREN   = 2'd3;

	// classified commands, front to back
	localparam logic [2:0] CMD_OPERAND  = 3'd0;
	localparam logic [2:0] CMD_OPERATOR = 3'd1;
	localparam logic [2:0] CMD_LPAREN   = 3'd2;
	localparam logic [2:0] CMD_RPAREN   = 3'd3;
	localparam logic [2:0] CMD_END      = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_END      = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_CLOSE    = 2'd1;
	localparam logic [1:0] ERR_OPEN     = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	// stack entry: operator code 0..3, or the left parenthesis mark
	localparam logic [ENT_W-1:0] LPAREN_MARK = 3'd4;

	typedef struct packed {
		logic [2:0]       kind;
		logic [1:0]       code;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       opr;
		logic [VAL_W-1:0] value;
		logic [1:0]       err;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

>>> src/itp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/itp_fifo.sv
// Small register-based queue with full/empty flags.
// No dependencies; used for the command queue and the result queue.
`default_nettype none

module itp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/itp_front.sv
// Front end: classifies incoming tokens into commands and queues them.
// Depends on itp_pkg and itp_fifo.
`default_nettype none

module itp_front #(
	parameter int VALUE_BITS = itp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic                    op,
	input  wire logic [1:0]              token_kind,
	input  wire logic [1:0]              operator_code,
	input  wire logic [itp_pkg::VAL_W-1:0] operand_value,
	input  wire logic                    cmd_pop,
	output logic                         cmd_valid,
	output itp_pkg::cmd_t                cmd
);

	localparam int MB = (VALUE_BITS < itp_pkg::VAL_W) ? VALUE_BITS : itp_pkg::VAL_W;
	localparam logic [itp_pkg::VAL_W-1:0] VAL_MASK =
		{itp_pkg::VAL_W{1'b1}} >> (itp_pkg::VAL_W - MB);

	itp_pkg::cmd_t cmd_in;
	logic          cmd_empty;

	always_comb begin
		cmd_in.code  = operator_code;
		cmd_in.value = operand_value & VAL_MASK;
		if (op) begin
			cmd_in.kind = itp_pkg::CMD_END;
		end else begin
			unique case (token_kind)
				itp_pkg::TOK_OPERAND:  cmd_in.kind = itp_pkg::CMD_OPERAND;
				itp_pkg::TOK_OPERATOR: cmd_in.kind = itp_pkg::CMD_OPERATOR;
				itp_pkg::TOK_LPAREN:   cmd_in.kind = itp_pkg::CMD_LPAREN;
				itp_pkg::TOK_RPAREN:   cmd_in.kind = itp_pkg::CMD_RPAREN;
				default:               cmd_in.kind = itp_pkg::CMD_OPERAND;
			endcase
		end
	end

	itp_fifo #(
		.WIDTH ($bits(itp_pkg::cmd_t)),
		.DEPTH (itp_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

>>> src/itp_back.sv
// Back end: operator stack and the shunting-yard step, one action per cycle while the result queue has room.
// Depends on itp_pkg and itp_ram.
`default_nettype none

module itp_back #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire itp_pkg::cmd_t cmd,
	output logic               cmd_pop,
	input  wire logic          out_full,
	output logic               res_push,
	output itp_pkg::res_t      res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]              count_q, count_d, under_cnt;
	logic                       disc_q;
	logic [itp_pkg::ENT_W-1:0]  top_q, under, push_ent;
	logic                       has_top, has_under, top_lp, under_lp, stk_full;
	logic                       top_pops, under_pops;
	logic                       emit, stk_push, stk_pop, stk_clear, disc_set, disc_clr;

	// top of stack lives in top_q; the RAM returns the entry beneath it
	itp_ram #(
		.WIDTH (itp_pkg::ENT_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_push),
		.waddr (count_q[AW-1:0]),
		.wdata (push_ent),
		.raddr (under_cnt[AW-1:0]),
		.rdata (under)
	);

	assign under_cnt  = count_d - CW'(2);
	assign has_top    = (count_q != '0);
	assign has_under  = (count_q > CW'(1));
	assign top_lp     = (top_q == itp_pkg::LPAREN_MARK);
	assign under_lp   = (under == itp_pkg::LPAREN_MARK);
	assign stk_full   = (count_q == CW'(STACK_DEPTH));
	// stacked operator leaves when its precedence is equal or higher
	assign top_pops   = has_top && !top_lp && (top_q[1] || !cmd.code[1]);
	assign under_pops = has_under && !under_lp && (under[1] || !cmd.code[1]);

	always_comb begin
		emit      = 1'b0;
		cmd_pop   = 1'b0;
		stk_push  = 1'b0;
		stk_pop   = 1'b0;
		stk_clear = 1'b0;
		disc_set  = 1'b0;
		disc_clr  = 1'b0;
		push_ent  = itp_pkg::LPAREN_MARK;
		res       = '0;
		if (cmd_valid) begin
			if (disc_q && cmd.kind != itp_pkg::CMD_END) begin
				cmd_pop = 1'b1;
			end else begin
				unique case (cmd.kind)
					itp_pkg::CMD_OPERAND: begin
						emit      = 1'b1;
						res.kind  = itp_pkg::KIND_OPERAND;
						res.value = cmd.value;
						res.last  = 1'b1;
						cmd_pop   = 1'b1;
					end
					itp_pkg::CMD_LPAREN: begin
						cmd_pop = 1'b1;
						if (stk_full) begin
							emit      = 1'b1;
							res.kind  = itp_pkg::KIND_ERROR;
							res.err   = itp_pkg::ERR_OVERFLOW;
							res.last  = 1'b1;
							stk_clear = 1'b1;
							disc_set  = 1'b1;
						end else begin
							stk_push = 1'b1;
						end
					end
					itp_pkg::CMD_OPERATOR: begin
						if (top_pops) begin
							emit     = 1'b1;
							res.kind = itp_pkg::KIND_OPERATOR;
							res.opr  = top_q[1:0];
							res.last = !under_pops;
							stk_pop  = 1'b1;
						end else if (stk_full) begin
							emit      = 1'b1;
							res.kind  = itp_pkg::KIND_ERROR;
							res.err   = itp_pkg::ERR_OVERFLOW;
							res.last  = 1'b1;
							stk_clear = 1'b1;
							disc_set  = 1'b1;
							cmd_pop   = 1'b1;
						end else begin
							stk_push = 1'b1;
							push_ent = {1'b0, cmd.code};
							cmd_pop  = 1'b1;
						end
					end
					itp_pkg::CMD_RPAREN: begin
						if (!has_top) begin
							emit      = 1'b1;
							res.kind  = itp_pkg::KIND_ERROR;
							res.err   = itp_pkg::ERR_CLOSE;
							res.last  = 1'b1;
							stk_clear = 1'b1;
							disc_set  = 1'b1;
							cmd_pop   = 1'b1;
						end else if (top_lp) begin
							stk_pop = 1'b1;
							cmd_pop = 1'b1;
						end else begin
							emit     = 1'b1;
							res.kind = itp_pkg::KIND_OPERATOR;
							res.opr  = top_q[1:0];
							res.last = has_under && under_lp;
							stk_pop  = 1'b1;
						end
					end
					itp_pkg::CMD_END: begin
						if (disc_q || !has_top) begin
							emit      = 1'b1;
							res.kind  = itp_pkg::KIND_END;
							res.last  = 1'b1;
							stk_clear = 1'b1;
							disc_clr  = 1'b1;
							cmd_pop   = 1'b1;
						end else if (top_lp) begin
							// unmatched open: drop the rest, end marker follows
							emit      = 1'b1;
							res.kind  = itp_pkg::KIND_ERROR;
							res.err   = itp_pkg::ERR_OPEN;
							stk_clear = 1'b1;
						end else begin
							emit     = 1'b1;
							res.kind = itp_pkg::KIND_OPERATOR;
							res.opr  = top_q[1:0];
							stk_pop  = 1'b1;
						end
					end
					default: begin
						cmd_pop = 1'b1;
					end
				endcase
			end
		end
		// hold everything while the result queue cannot take a word
		if (emit && out_full) begin
			cmd_pop   = 1'b0;
			stk_push  = 1'b0;
			stk_pop   = 1'b0;
			stk_clear = 1'b0;
			disc_set  = 1'b0;
			disc_clr  = 1'b0;
		end
		res_push = emit && !out_full;
	end

	always_comb begin
		priority if (stk_clear) begin
			count_d = '0;
		end else if (stk_push) begin
			count_d = count_q + 1'b1;
		end else if (stk_pop) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_push) begin
			top_q <= push_ent;
		end else if (stk_pop) begin
			top_q <= under;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			disc_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (disc_set) begin
				disc_q <= 1'b1;
			end else if (disc_clr) begin
				disc_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_disc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> (count_q == '0))
		else $error("stack not empty while discarding");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.kind == itp_pkg::CMD_END) |=> (count_q == '0 && !disc_q))
		else $error("end item left state behind");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == itp_pkg::KIND_ERROR) |=> (count_q == '0))
		else $error("error result did not clear the stack");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		stk_push |=> (top_q == $past(push_ent) && count_q == $past(count_q) + 1'b1))
		else $error("push did not update top of stack");

endmodule

`default_nettype wire

>>> src/infix_to_postfix_converter_core.sv
// Top level of the infix-to-postfix converter: front end, back end, result queue.
// Depends on itp_pkg, itp_front, itp_back and itp_fifo.
//
//  channel  | handshake       | words
//  ---------+-----------------+--------------------------------------------------
//  input    | push / full     | op, token_kind, operator_code, operand_value
//  result   | empty / pop     | out_kind, out_operator, out_value, error_code, last
//
// Steps: the back end takes one action per token, plus one action for every
// stacked operator that the token releases; an end item takes one action per
// flushed entry plus one for the end marker. Words pass through both queues.
// Reset: asynchronous, clears the queues, stack count and discard flag; the
// stack RAM is not cleared, so there is no clearing pass after reset.
// Stalls: a full result queue holds the back end; a full command queue
// raises full on the input side.
`default_nettype none

module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_BITS  = itp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic                      op,
	input  wire logic [1:0]                token_kind,
	input  wire logic [1:0]                operator_code,
	input  wire logic [itp_pkg::VAL_W-1:0] operand_value,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [1:0]                     out_kind,
	output logic [1:0]                     out_operator,
	output logic [itp_pkg::VAL_W-1:0]      out_value,
	output logic [1:0]                     error_code,
	output logic                           last
);

	itp_pkg::cmd_t cmd;
	itp_pkg::res_t res, res_head;
	logic          cmd_valid, cmd_pop, res_push, res_full;

	// classify and queue incoming tokens
	itp_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.op            (op),
		.token_kind    (token_kind),
		.operator_code (operator_code),
		.operand_value (operand_value),
		.cmd_pop       (cmd_pop),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd)
	);

	// run the operator stack; advance one action per cycle while the result queue has room
	itp_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// hold finished words until the consumer pops them
	itp_fifo #(
		.WIDTH ($bits(itp_pkg::res_t)),
		.DEPTH (itp_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign out_kind     = res_head.kind;
	assign out_operator = res_head.opr;
	assign out_value    = res_head.value;
	assign error_code   = res_head.err;
	assign last         = res_head.last;

endmodule

`default_nettype wire
